FILE: sv/gdbt_pkg.sv
// Shared types, constants and codes for the graph traversal unit.
`default_nettype none
package gdbt_pkg;
  localparam int Vertices   = 32;
  localparam int MaxDegree  = 32;
  localparam int VW         = $clog2(Vertices);
  localparam int DW         = $clog2(MaxDegree);
  localparam int CW         = DW + 1;
  localparam int AW         = VW + DW;
  localparam int Depth      = Vertices * MaxDegree;
  localparam int StackDepth = (Vertices < 32) ? Vertices : 32;
  localparam int SW         = $clog2(StackDepth);
  localparam int SPW        = SW + 1;
  localparam int RW         = 6;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_EDGE  = 2'd1,
    ACT_DFS   = 2'd2,
    ACT_BFS   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture input word
    logic clr_graph;  // zero neighbor counts
    logic clr_marks;  // zero visited marks
    logic edge_wr_b;  // append a to b's list
    logic edge_wr_a;  // append b to a's list
    logic dfs_init;   // push start
    logic bfs_init;   // enqueue start
    logic rd_issue;   // read neighbor of top/head
    logic dfs_adv;    // process read neighbor (DFS)
    logic dfs_pop;    // pop stack
    logic bfs_adv;    // process read neighbor (BFS)
    logic bfs_deq;    // dequeue head
    logic out_load;   // place result in output register
    logic out_last;
    logic [1:0] out_status;
    logic out_vtx_sel; // 1: vertex from emit register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    action_t act;
    logic    a_bad;
    logic    b_bad;
    logic    full;
    logic    has_next;  // top/head has unread neighbor
    logic    take;      // read neighbor is new and fits
    logic    stack_one; // one entry left on stack
    logic    q_last;    // head is last queued entry
  } stat_t;
endpackage
`default_nettype wire

FILE: sv/gdbt_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module gdbt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write or read one entry
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

FILE: sv/gdbt_datapath.sv
// Datapath: graph storage, marks, stack, queue and output register.
`default_nettype none
module gdbt_datapath (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire gdbt_pkg::cmd_t        cmd,
  input  wire logic [1:0]            in_action,
  input  wire logic [gdbt_pkg::VW-1:0] in_a,
  input  wire logic [gdbt_pkg::VW-1:0] in_b,
  input  wire logic [5:0]            vcount,
  output gdbt_pkg::stat_t            stat,
  output logic [gdbt_pkg::VW-1:0]    out_vtx,
  output logic                       out_last,
  output logic [1:0]                 out_status
);
  localparam int VW = gdbt_pkg::VW;
  localparam int CW = gdbt_pkg::CW;
  localparam int DW = gdbt_pkg::DW;
  localparam int SW = gdbt_pkg::SW;
  localparam int SPW = gdbt_pkg::SPW;

  logic [1:0]    act;
  logic [VW-1:0] va, vb, emit_v;
  logic [CW-1:0] ncount [gdbt_pkg::Vertices];
  logic [gdbt_pkg::Vertices-1:0] marks;
  logic [VW-1:0] stk_v [gdbt_pkg::StackDepth];
  logic [CW-1:0] stk_i [gdbt_pkg::StackDepth];
  logic [SPW-1:0] sp;
  logic [VW-1:0] que [gdbt_pkg::StackDepth];
  logic [SPW-1:0] head, tail;
  logic [CW-1:0] bfs_j;

  logic [6:0]    n_eff;
  logic [VW-1:0] cur_v;
  logic [CW-1:0] cur_idx;
  logic          ram_we;
  logic [gdbt_pkg::AW-1:0] ram_addr;
  logic [VW-1:0] ram_wdata, nb;
  logic [CW+1:0] need_a, need_b;

  assign n_eff = (vcount > 6'(gdbt_pkg::StackDepth)) ? 7'(gdbt_pkg::StackDepth) : {1'b0, vcount};
  assign cur_v   = (act == gdbt_pkg::ACT_DFS) ? stk_v[SW'(sp - 1'b1)] : que[SW'(head)];
  assign cur_idx = (act == gdbt_pkg::ACT_DFS) ? stk_i[SW'(sp - 1'b1)] : bfs_j;

  // Select RAM access: edge appends or neighbor read
  always_comb begin
    ram_we = cmd.edge_wr_a | cmd.edge_wr_b;
    ram_wdata = va;
    ram_addr = {cur_v, cur_idx[DW-1:0]};
    if (cmd.edge_wr_b) begin
      ram_addr = {vb, ncount[vb][DW-1:0]};
      ram_wdata = va;
    end else if (cmd.edge_wr_a) begin
      ram_addr = {va, ncount[va][DW-1:0]};
      ram_wdata = vb;
    end
  end

  gdbt_ram #(.Width(VW), .Depth(gdbt_pkg::Depth)) u_table (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(nb)
  );

  // Status toward controller
  assign need_a = (CW+2)'(ncount[va]) + ((va == vb) ? (CW+2)'(2) : (CW+2)'(1));
  assign need_b = (CW+2)'(ncount[vb]) + ((va == vb) ? (CW+2)'(2) : (CW+2)'(1));
  always_comb begin
    stat.act = gdbt_pkg::action_t'(act);
    stat.a_bad = {2'b0, va} >= n_eff;
    stat.b_bad = {2'b0, vb} >= n_eff;
    stat.full = (need_a > (CW+2)'(gdbt_pkg::MaxDegree)) || (need_b > (CW+2)'(gdbt_pkg::MaxDegree));
    stat.has_next = cur_idx < ncount[cur_v];
    stat.take = ({2'b0, nb} < n_eff) && !marks[nb] &&
      ((act == gdbt_pkg::ACT_DFS) ? (sp < SPW'(gdbt_pkg::StackDepth))
                                  : (tail < SPW'(gdbt_pkg::StackDepth)));
    stat.stack_one = sp == SPW'(1);
    stat.q_last = (head + 1'b1) == tail;
  end

  // Hold input word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= in_action;
      va <= in_a;
      vb <= in_b;
    end
  end

  // Neighbor counts
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_graph) begin
      for (int i = 0; i < gdbt_pkg::Vertices; i++) ncount[i] <= '0;
    end else if (cmd.edge_wr_b) begin
      ncount[vb] <= ncount[vb] + 1'b1;
    end else if (cmd.edge_wr_a) begin
      ncount[va] <= ncount[va] + 1'b1;
    end
  end

  // Walk state: marks, stack, queue
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_marks) begin
      marks <= '0;
    end else if (cmd.dfs_init || cmd.bfs_init) begin
      marks[va] <= 1'b1;
    end else if ((cmd.dfs_adv || cmd.bfs_adv) && stat.take) begin
      marks[nb] <= 1'b1;
    end
    if (cmd.dfs_init) begin
      stk_v[0] <= va;
      stk_i[0] <= '0;
      sp <= SPW'(1);
      emit_v <= va;
    end
    if (cmd.rd_issue && act == gdbt_pkg::ACT_DFS) begin
      stk_i[SW'(sp - 1'b1)] <= stk_i[SW'(sp - 1'b1)] + 1'b1;
    end
    if (cmd.dfs_adv && stat.take) begin
      stk_v[SW'(sp)] <= nb;
      stk_i[SW'(sp)] <= '0;
      sp <= sp + 1'b1;
      emit_v <= nb;
    end
    if (cmd.dfs_pop) sp <= sp - 1'b1;
    if (cmd.bfs_init) begin
      que[0] <= va;
      head <= '0;
      tail <= SPW'(1);
      bfs_j <= '0;
      emit_v <= va;
    end
    if (cmd.rd_issue && act == gdbt_pkg::ACT_BFS) bfs_j <= bfs_j + 1'b1;
    if (cmd.bfs_adv && stat.take) begin
      que[SW'(tail)] <= nb;
      tail <= tail + 1'b1;
    end
    if (cmd.bfs_deq) begin
      head <= head + 1'b1;
      bfs_j <= '0;
      emit_v <= que[SW'(head + 1'b1)];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_vtx <= cmd.out_vtx_sel ? emit_v : '0;
      out_last <= cmd.out_last;
      out_status <= cmd.out_status;
    end
  end
endmodule
`default_nettype wire

FILE: sv/gdbt_ctrl.sv
// Controller state machine sequencing each action.
`default_nettype none
module gdbt_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire gdbt_pkg::stat_t stat,
  output gdbt_pkg::cmd_t       cmd
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_DEC   = 8'b00000010,
    S_EDGE  = 8'b00000100,
    S_OUT   = 8'b00001000,
    S_EMIT  = 8'b00010000,
    S_READ  = 8'b00100000,
    S_ADV   = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  state_t state, state_next;
  logic   out_take;

  assign out_take = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && !out_valid;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        unique case (stat.act)
          gdbt_pkg::ACT_CLEAR: begin
            cmd.clr_graph = 1'b1;
            cmd.out_load = 1'b1;
            cmd.out_last = 1'b1;
            cmd.out_status = gdbt_pkg::ST_OK;
            state_next = S_OUT;
          end
          gdbt_pkg::ACT_EDGE: begin
            cmd.out_load = 1'b1;
            cmd.out_last = 1'b1;
            if (stat.a_bad || stat.b_bad) begin
              cmd.out_status = gdbt_pkg::ST_RANGE;
              state_next = S_OUT;
            end else if (stat.full) begin
              cmd.out_status = gdbt_pkg::ST_FULL;
              state_next = S_OUT;
            end else begin
              cmd.out_status = gdbt_pkg::ST_OK;
              cmd.edge_wr_b = 1'b1;
              state_next = S_EDGE;
            end
          end
          default: begin
            if (stat.a_bad) begin
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
              cmd.out_status = gdbt_pkg::ST_RANGE;
              state_next = S_OUT;
            end else begin
              cmd.clr_marks = 1'b1;
              state_next = S_EMIT;
            end
          end
        endcase
      end
      S_EDGE: begin
        cmd.edge_wr_a = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        // Leave once the result word is gone or going
        if (out_take) state_next = S_IDLE;
      end
      S_EMIT: begin
        // Push or enqueue start vertex
        if (stat.act == gdbt_pkg::ACT_DFS) begin
          cmd.dfs_init = 1'b1;
        end else begin
          cmd.bfs_init = 1'b1;
        end
        state_next = S_READ;
      end
      S_READ: begin
        if (stat.act == gdbt_pkg::ACT_DFS) begin
          // Read only with the output free, a push may send a word
          if (stat.has_next) begin
            if (out_take) begin
              cmd.rd_issue = 1'b1;
              state_next = S_ADV;
            end
          end else if (stat.stack_one) begin
            state_next = S_DONE;
          end else begin
            cmd.dfs_pop = 1'b1;
          end
        end else begin
          if (stat.has_next) begin
            cmd.rd_issue = 1'b1;
            state_next = S_ADV;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_ADV: begin
        if (stat.act == gdbt_pkg::ACT_DFS) begin
          cmd.dfs_adv = 1'b1;
          // A new push releases the vertex held before it
          if (stat.take) begin
            cmd.out_load = 1'b1;
            cmd.out_vtx_sel = 1'b1;
          end
        end else begin
          cmd.bfs_adv = 1'b1;
        end
        state_next = S_READ;
      end
      S_DONE: begin
        // Send vertex; the held DFS vertex or the final BFS one carries last
        if (out_take) begin
          cmd.out_load = 1'b1;
          cmd.out_vtx_sel = 1'b1;
          if (stat.act == gdbt_pkg::ACT_DFS) begin
            cmd.out_last = 1'b1;
            state_next = S_OUT;
          end else if (stat.q_last) begin
            cmd.out_last = 1'b1;
            state_next = S_OUT;
          end else begin
            cmd.bfs_deq = 1'b1;
            state_next = S_READ;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Raise valid on a load, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

FILE: sv/graph_dfs_bfs_traversal_unit.sv
// Top level of the graph traversal unit.
// Clear goes from the accepted word through the decode state to the output
// state; add-edge writes one list in decode and the other in its own edge
// state. A run reads each neighbor-list entry through the single port of the
// neighbor table (one registered read at a time), pops each vertex
// (depth-first) or sends it (breadth-first), with start and finish steps; a
// depth-first run also waits at each new vertex until the previous result
// word is taken. The table holds up to 32 vertices of degree 32.
// One item at a time.
`default_nettype none
module graph_dfs_bfs_traversal_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // action[1:0], vertex_a[6:2], vertex_b[11:7]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // visited_vertex[4:0], status[6:5]
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data       // vertex_count[5:0]
);
  gdbt_pkg::cmd_t  cmd;
  gdbt_pkg::stat_t stat;
  logic [5:0] vcount;
  logic [4:0] ovtx;
  logic [1:0] ostat;
  logic       ostrobe_last, dvalid;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) vcount <= 6'd32;
    else if (cfg_valid) vcount <= cfg_data[5:0];
  end

  gdbt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(dvalid), .out_ready(m_axis_tready), .stat(stat), .cmd(cmd)
  );

  gdbt_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_action(s_axis_tdata[1:0]),
    .in_a(s_axis_tdata[6:2]), .in_b(s_axis_tdata[11:7]), .vcount(vcount),
    .stat(stat), .out_vtx(ovtx), .out_last(ostrobe_last), .out_status(ostat)
  );

  assign m_axis_tvalid = dvalid;
  assign m_axis_tdata  = {1'b0, ostat, ovtx};
  assign m_axis_tlast  = ostrobe_last;
endmodule
`default_nettype wire

FILE: sv/gdbt_checker.sv
// Port-level checker for the graph traversal unit.
`default_nettype none
module gdbt_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast
);
  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  // Error results are always final
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[6:5] != gdbt_pkg::ST_OK |-> m_axis_tlast)
    else $error("error result not last");
  // Error results carry vertex zero
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[6:5] != gdbt_pkg::ST_OK |-> m_axis_tdata[4:0] == 5'd0)
    else $error("error result with vertex");
  // No new word taken while a result waits
  a_one: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(s_axis_tvalid && s_axis_tready))
    else $error("input accepted with result pending");
endmodule

bind graph_dfs_bfs_traversal_unit gdbt_checker u_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire
